// ===== sv/qaec_pkg.sv =====
`timescale 1ns / 1ps

package qaec_pkg;

    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int QWORDS           = 10;
    localparam int ACC_W            = 132;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;
    localparam logic [62:0] COST_MAX = {63{1'b1}};

    typedef enum logic [1:0] {
        OP_POS   = 2'd0,
        OP_FACE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FACE,
        ST_QPOS,
        ST_QSUM,
        ST_QFIN,
        ST_QOUT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [9:0]        vert_a;
        logic [9:0]        vert_b;
        logic [9:0]        vert_c;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
        logic signed [31:0] val_w;
    } in_t;

    typedef struct packed {
        logic [62:0]        edge_cost;
        logic signed [31:0] mid_x;
        logic signed [31:0] mid_y;
        logic signed [31:0] mid_z;
        logic               cost_saturated;
    } out_t;

    typedef struct packed {
        logic       clear;
        logic       part_en;
        logic [1:0] part_sel;
        logic       dbl;
    } acc_ctl_t;

    typedef struct packed {
        logic        ovf;
        logic [63:0] sum;
    } sat_res_t;

    function automatic sat_res_t sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        sat_res_t    res;
        r       = a + b;
        res.ovf = ~(a[63] ^ b[63]) & (a[63] ^ r[63]);
        if (res.ovf)
        begin
            res.sum = a[63] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res.sum = r;
        end
        return res;
    endfunction

    // Upper-triangle word order: q00 q01 q02 q03 q11 q12 q13 q22 q23 q33.
    function automatic logic [1:0] qrow(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd5, 4'd6:       r = 2'd1;
            4'd7, 4'd8:             r = 2'd2;
            4'd9:                   r = 2'd3;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] qcol(input logic [3:0] k);
        logic [1:0] c;
        unique case (k)
            4'd0:                   c = 2'd0;
            4'd1, 4'd4:             c = 2'd1;
            4'd2, 4'd5, 4'd7:       c = 2'd2;
            4'd3, 4'd6, 4'd8, 4'd9: c = 2'd3;
            default:                c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/quadric_accumulate_edge_cost.sv =====
`timescale 1ns / 1ps

// Quadric store with edge cost. After reset the block clears all 10 * VERTEX_COUNT words
// of its quadric memory, one word a cycle, and accepts no transaction until that is done. A
// position write goes to the position memory. For a face add the quadric memory has one
// read and one write port, so the ten words of each of the three vertices go through a
// read, saturating add and write back at one word a cycle. An edge query reads the two
// positions and forms their midpoint; then for each quadric word it reads and adds both
// endpoints' words, multiplies the midpoint terms in the shared multiplier and pushes four
// 33x33 partial products into the cost accumulator, and ends in ST_QFIN and ST_QOUT. The
// result waits in an output register, and the next transaction is taken while it waits,
// except that a later query cannot finish before the earlier result has been taken.
module quadric_accumulate_edge_cost
    import qaec_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int AW     = $clog2(VERTEX_COUNT);
    localparam int QDEPTH = VERTEX_COUNT * QWORDS;
    localparam int QAW    = $clog2(QDEPTH);

    function automatic logic [AW-1:0] vidx(input logic [9:0] v);
        logic [16:0] e;
        e = {7'b0, v};
        return e[AW-1:0];
    endfunction

    function automatic logic vok(input logic [9:0] v);
        return {22'b0, v} < VERTEX_COUNT;
    endfunction

    function automatic logic [QAW-1:0] qaddr(input logic [9:0] v, input logic [3:0] k);
        logic [31:0] t;
        t = 32'(vidx(v)) * 32'(QWORDS) + {28'b0, k};
        return t[QAW-1:0];
    endfunction

    logic [63:0] quad_mem [QDEPTH];
    logic [95:0] pos_mem [VERTEX_COUNT];

    state_t          st_reg, st_next;
    logic [1:0]      fv_reg, fv_next;
    logic [3:0]      k_reg, k_next;
    logic [2:0]      sub_reg, sub_next;
    logic [QAW-1:0]  clr_reg;
    logic            wr_pend_reg;
    logic [QAW-1:0]  wr_addr_reg;
    logic            out_valid_reg;
    out_t            out_reg;
    in_t             in_reg;

    logic [63:0]        q_rdata_reg;
    logic [95:0]        p_rdata_reg;
    logic signed [63:0] prod_reg;
    logic [95:0]        pa_reg;
    logic signed [31:0] mid_x_reg, mid_y_reg, mid_z_reg;
    logic [63:0]        qa_reg;
    logic [63:0]        qsum_reg;
    logic               sat_reg;

    logic               accept;
    logic               pos_we;
    logic               q_we;
    logic [QAW-1:0]     q_waddr;
    logic [63:0]        q_wdata;
    logic [QAW-1:0]     q_raddr;
    logic [AW-1:0]      p_raddr;
    logic               face_issue;
    logic               mul_en;
    logic signed [31:0] mul_a, mul_b;
    logic               cap_pa, cap_mid, cap_qa, cap_qsum, load_out;
    logic [9:0]         fvert;
    logic [2:0]         sub_off;
    acc_ctl_t           acc_ctl;
    logic [62:0]        cost;
    logic               cost_ovf;
    sat_res_t           face_sum;
    sat_res_t           q_sum;
    logic [63:0]        qb;
    logic [95:0]        pb;
    logic signed [32:0] sx, sy, sz;

    assign in_ready  = (st_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign sub_off   = sub_reg - 3'd3;

    function automatic logic signed [31:0] fval(input in_t d, input logic [1:0] r);
        logic signed [31:0] v;
        unique case (r)
            2'd0: v = d.val_x;
            2'd1: v = d.val_y;
            2'd2: v = d.val_z;
            2'd3: v = d.val_w;
            default: v = d.val_x;
        endcase
        return v;
    endfunction

    always_comb
    begin
        unique case (fv_reg)
            2'd0:    fvert = in_reg.vert_a;
            2'd1:    fvert = in_reg.vert_b;
            default: fvert = in_reg.vert_c;
        endcase
    end

    function automatic logic signed [31:0] pval(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z,
                                                 input logic [1:0] r);
        logic signed [31:0] v;
        unique case (r)
            2'd0: v = x;
            2'd1: v = y;
            2'd2: v = z;
            2'd3: v = ONE_Q16;
            default: v = x;
        endcase
        return v;
    endfunction

    always_comb
    begin
        st_next    = st_reg;
        fv_next    = fv_reg;
        k_next     = k_reg;
        sub_next   = sub_reg;
        pos_we     = 1'b0;
        q_raddr    = '0;
        p_raddr    = '0;
        face_issue = 1'b0;
        mul_en     = 1'b0;
        mul_a      = fval(in_reg, qrow(k_reg));
        mul_b      = fval(in_reg, qcol(k_reg));
        cap_pa     = 1'b0;
        cap_mid    = 1'b0;
        cap_qa     = 1'b0;
        cap_qsum   = 1'b0;
        load_out   = 1'b0;
        acc_ctl    = '0;

        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_reg == QAW'(QDEPTH - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    fv_next  = 2'd0;
                    k_next   = 4'd0;
                    sub_next = 3'd0;
                    unique case (in_data.op)
                        OP_POS:   pos_we = vok(in_data.vert_a);
                        OP_FACE:  st_next = ST_FACE;
                        OP_QUERY:
                        begin
                            st_next       = ST_QPOS;
                            acc_ctl.clear = 1'b1;
                        end
                        default:  st_next = ST_IDLE;
                    endcase
                end
            end
            ST_FACE:
            begin
                if (vok(fvert))
                begin
                    q_raddr    = qaddr(fvert, k_reg);
                    face_issue = 1'b1;
                    mul_en     = 1'b1;
                end
                // An out-of-range vertex is skipped without a read or write of the quadric memory.
                if (!vok(fvert) || k_reg == 4'(QWORDS - 1))
                begin
                    k_next = 4'd0;
                    if (fv_reg == 2'd2)
                    begin
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        fv_next = fv_reg + 2'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_QPOS:
            begin
                sub_next = sub_reg + 3'd1;
                unique case (sub_reg)
                    3'd0:    p_raddr = vidx(in_reg.vert_a);
                    3'd1:
                    begin
                        p_raddr = vidx(in_reg.vert_b);
                        cap_pa  = 1'b1;
                    end
                    default:
                    begin
                        cap_mid  = 1'b1;
                        sub_next = 3'd0;
                        st_next  = ST_QSUM;
                    end
                endcase
            end
            ST_QSUM:
            begin
                sub_next = sub_reg + 3'd1;
                mul_a    = pval(mid_x_reg, mid_y_reg, mid_z_reg, qrow(k_reg));
                mul_b    = pval(mid_x_reg, mid_y_reg, mid_z_reg, qcol(k_reg));
                unique case (sub_reg)
                    3'd0: q_raddr = qaddr(in_reg.vert_a, k_reg);
                    3'd1:
                    begin
                        q_raddr = qaddr(in_reg.vert_b, k_reg);
                        cap_qa  = 1'b1;
                    end
                    3'd2:
                    begin
                        cap_qsum = 1'b1;
                        mul_en   = 1'b1;
                    end
                    default:
                    begin
                        acc_ctl.part_en  = 1'b1;
                        acc_ctl.part_sel = sub_off[1:0];
                        acc_ctl.dbl      = (qrow(k_reg) != qcol(k_reg));
                        if (sub_reg == 3'd6)
                        begin
                            sub_next = 3'd0;
                            if (k_reg == 4'(QWORDS - 1))
                            begin
                                st_next = ST_QFIN;
                            end
                            else
                            begin
                                k_next = k_reg + 4'd1;
                            end
                        end
                    end
                endcase
            end
            ST_QFIN:
            begin
                st_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assign face_sum = sat_add(q_rdata_reg, prod_reg);
    assign q_we     = (st_reg == ST_CLEAR) || wr_pend_reg;
    assign q_waddr  = (st_reg == ST_CLEAR) ? clr_reg : wr_addr_reg;
    assign q_wdata  = (st_reg == ST_CLEAR) ? 64'd0 : face_sum.sum;

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            quad_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= quad_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[vidx(in_data.vert_a)] <= {in_data.val_z, in_data.val_y, in_data.val_x};
        end
        p_rdata_reg <= pos_mem[p_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            fv_reg        <= 2'd0;
            k_reg         <= 4'd0;
            sub_reg       <= 3'd0;
            clr_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            fv_reg      <= fv_next;
            k_reg       <= k_next;
            sub_reg     <= sub_next;
            wr_pend_reg <= face_issue;
            if (st_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign qb = vok(in_reg.vert_b) ? q_rdata_reg : 64'd0;
    assign q_sum = sat_add(qa_reg, qb);
    assign pb = vok(in_reg.vert_b) ? p_rdata_reg : 96'd0;
    assign sx = {pa_reg[31], pa_reg[31:0]} + {pb[31], pb[31:0]};
    assign sy = {pa_reg[63], pa_reg[63:32]} + {pb[63], pb[63:32]};
    assign sz = {pa_reg[95], pa_reg[95:64]} + {pb[95], pb[95:64]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg  <= in_data;
            sat_reg <= 1'b0;
        end
        else if (cap_qsum)
        begin
            sat_reg <= sat_reg | q_sum.ovf;
        end
        if (face_issue)
        begin
            wr_addr_reg <= q_raddr;
        end
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cap_pa)
        begin
            pa_reg <= vok(in_reg.vert_a) ? p_rdata_reg : 96'd0;
        end
        // The midpoint is the 33-bit sum shifted right, rounding toward minus infinity.
        if (cap_mid)
        begin
            mid_x_reg <= sx[32:1];
            mid_y_reg <= sy[32:1];
            mid_z_reg <= sz[32:1];
        end
        if (cap_qa)
        begin
            qa_reg <= vok(in_reg.vert_a) ? q_rdata_reg : 64'd0;
        end
        if (cap_qsum)
        begin
            qsum_reg <= q_sum.sum;
        end
        if (load_out)
        begin
            out_reg.edge_cost      <= cost;
            out_reg.mid_x          <= mid_x_reg;
            out_reg.mid_y          <= mid_y_reg;
            out_reg.mid_z          <= mid_z_reg;
            out_reg.cost_saturated <= sat_reg | cost_ovf;
        end
    end

    qaec_cost_acc u_cost_acc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (acc_ctl),
        .qsum (qsum_reg),
        .pp   (prod_reg),
        .cost (cost),
        .ovf  (cost_ovf)
    );

endmodule

// ===== sv/qaec_cost_acc.sv =====
`timescale 1ns / 1ps

module qaec_cost_acc
    import qaec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  acc_ctl_t    ctl,
    input  logic [63:0] qsum,
    input  logic [63:0] pp,
    output logic [62:0] cost,
    output logic        ovf
);

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic [6:0]         sh;
    logic signed [65:0] part_reg;
    logic [6:0]         sh_reg;
    logic               part_vld_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   part_ext;
    logic [99:0]        scaled;

    // Low halves are unsigned, high halves carry the sign.
    assign op_a = ctl.part_sel[1] ? {qsum[63], qsum[63:32]} : {1'b0, qsum[31:0]};
    assign op_b = ctl.part_sel[0] ? {pp[63], pp[63:32]} : {1'b0, pp[31:0]};
    assign sh   = {ctl.part_sel[1] & ctl.part_sel[0], ctl.part_sel[1] ^ ctl.part_sel[0], 5'b0}
                  + {6'b0, ctl.dbl};

    assign part_ext = {{(ACC_W-66){part_reg[65]}}, part_reg};
    assign acc_next = acc_reg + (part_ext << sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_vld_reg <= 1'b0;
        end
        else
        begin
            part_vld_reg <= ctl.part_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.part_en)
        begin
            part_reg <= op_a * op_b;
            sh_reg   <= sh;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (part_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign scaled = acc_reg[ACC_W-1:32];

    always_comb
    begin
        ovf  = 1'b0;
        cost = scaled[62:0];
        if (acc_reg[ACC_W-1])
        begin
            cost = '0;
        end
        else if (|scaled[99:63])
        begin
            cost = COST_MAX;
            ovf  = 1'b1;
        end
    end

endmodule

// ===== sv/qaec_check.sv =====
`timescale 1ns / 1ps

module qaec_check
    import qaec_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_QUERY |=> !in_ready)
        else $error("input taken during an edge query");

    a_face_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_FACE |=> !in_ready)
        else $error("input taken during a face add");

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a query in progress");

endmodule

bind quadric_accumulate_edge_cost qaec_check u_qaec_check (.*);
